>>> sv/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// double_ended_queue_defines
// assertion macros used by the double_ended_queue design file
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication
`define DQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// next-cycle implication
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

>>> sv/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// types and constants of the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DQ_DEPTH = 256;
  localparam int unsigned DQ_WIDTH = 32;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OCC_W   = 9;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] read_value;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

endpackage

>>> sv/dq_mem.sv
// ----------------------------------------------------------------------------
// dq_mem
// single-port word store with registered read data
// ----------------------------------------------------------------------------
module dq_mem #(
  parameter int unsigned DEPTH = dq_pkg::DQ_DEPTH,
  parameter int unsigned WIDTH = dq_pkg::DQ_WIDTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// double-ended queue of words in a circular single-port store
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (in_valid, in_ready, in_data) and carry a
// mode and a word: push or pop at either end, peek at either end, or clear.
// Every request gives exactly one response on the out channel (out_valid,
// out_ready, out_data) with a status, the word read and the new occupancy.
// Front, back and count registers are updated in the transfer cycle, and the
// store is written or read in that same cycle through its one port.
// A response is registered after its request transfer: the store read
// completes at the transfer edge and the output register loads once free.
// With out_ready high the block takes one request per cycle; the single store
// port and the pending stage limit it to one request in flight ahead of the
// output register.
// When the receiver stalls, the output register holds its response and one
// more request is taken into the pending stage; in_ready then drops until
// the response is taken.
// Reset empties the queue at once (pointers and count to zero) and drops any
// pending or held response; the store contents are left as they are.
// A push when full answers full, a pop or peek when empty answers empty, and
// neither changes the queue.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DQ_DEPTH,
  parameter int unsigned WIDTH = dq_pkg::DQ_WIDTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dq_pkg::req_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dq_pkg::rsp_t  out_data
);

  localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [AW-1:0] front;
  logic [AW-1:0] back;
  logic [CW-1:0] count;
  logic [AW-1:0] front_next;
  logic [AW-1:0] back_next;
  logic [CW-1:0] count_next;

  logic [AW-1:0] front_inc;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] back_inc;
  logic [AW-1:0] back_dec;

  logic full;
  logic empty;
  logic out_free;
  logic in_xfer;
  logic is_push;
  logic is_clear;

  dq_pkg::status_t st;
  logic            do_write;
  logic            do_read;
  logic [AW-1:0]   mem_addr;
  logic [WIDTH-1:0] wr_word;
  logic [WIDTH-1:0] rd_word;
  logic [WIDTH+dq_pkg::VALUE_W-1:0] wr_ext;
  logic [WIDTH+dq_pkg::VALUE_W-1:0] rd_ext;
  logic [CW+dq_pkg::OCC_W-1:0]      occ_ext;

  logic            pend;
  logic            pend_rd;
  dq_pkg::status_t pend_status;
  logic [dq_pkg::OCC_W-1:0] pend_occ;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign out_free = !out_valid || out_ready;
  assign in_ready = !pend || out_free;
  assign in_xfer  = in_valid && in_ready;
  assign is_push  = (in_data.mode == dq_pkg::MODE_PUSH_FRONT) ||
                    (in_data.mode == dq_pkg::MODE_PUSH_BACK);
  assign is_clear = (in_data.mode == dq_pkg::MODE_CLEAR);

  assign front_inc = (front == LAST_POS) ? '0 : front + AW'(1);
  assign front_dec = (front == '0) ? LAST_POS : front - AW'(1);
  assign back_inc  = (back == LAST_POS) ? '0 : back + AW'(1);
  assign back_dec  = (back == '0) ? LAST_POS : back - AW'(1);

  assign wr_ext  = {{WIDTH{1'b0}}, in_data.value};
  assign wr_word = wr_ext[WIDTH-1:0];
  assign rd_ext  = {{dq_pkg::VALUE_W{1'b0}}, rd_word};
  assign occ_ext = {{dq_pkg::OCC_W{1'b0}}, count_next};

  always_comb begin
    front_next = front;
    back_next  = back;
    count_next = count;
    st         = dq_pkg::STATUS_OK;
    do_write   = 1'b0;
    do_read    = 1'b0;
    mem_addr   = front;
    unique case (in_data.mode)
      dq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          st = dq_pkg::STATUS_FULL;
        end else begin
          front_next = front_dec;
          mem_addr   = front_dec;
          do_write   = 1'b1;
          count_next = count + CW'(1);
        end
      end
      dq_pkg::MODE_PUSH_BACK: begin
        if (full) begin
          st = dq_pkg::STATUS_FULL;
        end else begin
          back_next  = back_inc;
          mem_addr   = back;
          do_write   = 1'b1;
          count_next = count + CW'(1);
        end
      end
      dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_PEEK_FRONT: begin
        if (empty) begin
          st = dq_pkg::STATUS_EMPTY;
        end else begin
          mem_addr = front;
          do_read  = 1'b1;
          if (in_data.mode == dq_pkg::MODE_POP_FRONT) begin
            front_next = front_inc;
            count_next = count - CW'(1);
          end
        end
      end
      dq_pkg::MODE_POP_BACK, dq_pkg::MODE_PEEK_BACK: begin
        if (empty) begin
          st = dq_pkg::STATUS_EMPTY;
        end else begin
          mem_addr = back_dec;
          do_read  = 1'b1;
          if (in_data.mode == dq_pkg::MODE_POP_BACK) begin
            back_next  = back_dec;
            count_next = count - CW'(1);
          end
        end
      end
      dq_pkg::MODE_CLEAR: begin
        front_next = '0;
        back_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  dq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (in_xfer && do_write),
    .re    (in_xfer && do_read),
    .addr  (mem_addr),
    .wdata (wr_word),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      back      <= '0;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        front <= front_next;
        back  <= back_next;
        count <= count_next;
        pend  <= 1'b1;
      end else if (out_free) begin
        pend <= 1'b0;
      end
      if (pend && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_status <= st;
      pend_occ    <= occ_ext[dq_pkg::OCC_W-1:0];
      pend_rd     <= do_read;
    end
    if (pend && out_free) begin
      out_data.status     <= pend_status;
      out_data.read_value <= pend_rd ? rd_ext[dq_pkg::VALUE_W-1:0] : '0;
      out_data.occupancy  <= pend_occ;
    end
  end

  `DQ_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= FULL_CNT)
  `DQ_ASSERT_NEXT(a_full_push_holds, clk, rst, in_xfer && is_push && full, $stable(count))
  `DQ_ASSERT_NEXT(a_clear_zero, clk, rst, in_xfer && is_clear, empty && front == '0 && back == '0)
  `DQ_ASSERT_NEXT(a_pend_delivered, clk, rst, pend && out_free, out_valid)

endmodule

>>> tb/tb_double_ended_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// self-checking testbench of the double-ended queue
// ----------------------------------------------------------------------------
// A queue of requests is built up front: a short directed run over the empty
// and end cases, then random runs that fill the store to full, drain it to
// empty, clear it or mix all modes. A driver offers the requests on the in
// channel and computes the expected response of each transfer with its own
// deque model; a monitor checks every response field against the oldest
// expected one. Idle and stall rates change by phase, the receiver twice
// holds off long enough to stall the input, and the sender drains between
// phases.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;

  localparam int unsigned DEPTH_N     = dq_pkg::DQ_DEPTH;
  localparam int unsigned VW          = dq_pkg::VALUE_W;
  localparam int unsigned OW          = dq_pkg::OCC_W;
  localparam int unsigned PTR_W       = $clog2(DEPTH_N);
  localparam int          N_ITEMS     = 1200;
  localparam int          PHASE_LEN   = 150;
  localparam int          HOLD_CYCLES = 400;

  typedef enum {TODO_REQ, TODO_DRAIN, TODO_HOLD} todo_kind_e;

  typedef struct {
    todo_kind_e   kind;
    int           phase;
    dq_pkg::req_t req;
  } todo_t;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         in_valid  = 1'b0;
  logic         in_ready;
  dq_pkg::req_t in_data   = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  dq_pkg::rsp_t out_data;

  todo_t        requests_todo[$];
  dq_pkg::rsp_t answers_due[$];

  int n_sent    = 0;
  int n_recv    = 0;
  int fails     = 0;
  int cur_phase = 0;
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;

  // generation bookkeeping
  int gen_idx   = 0;
  int gen_held  = 0;
  int gen_phase = 0;

  // deque model state
  logic [VW-1:0]    model_mem [DEPTH_N];
  logic [PTR_W-1:0] front_pos = '0;
  logic [PTR_W-1:0] back_pos  = '0;
  logic [OW-1:0]    held      = '0;

  double_ended_queue uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic dq_pkg::rsp_t deque_answer(dq_pkg::req_t r);
    dq_pkg::rsp_t     a;
    logic [PTR_W-1:0] last;
    a.status     = dq_pkg::STATUS_OK;
    a.read_value = '0;
    case (r.mode)
      dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
        if (held == OW'(DEPTH_N)) begin
          a.status = dq_pkg::STATUS_FULL;
        end else if (r.mode == dq_pkg::MODE_PUSH_FRONT) begin
          front_pos = front_pos - 1'b1;
          model_mem[front_pos] = r.value;
          held = held + 1'b1;
        end else begin
          model_mem[back_pos] = r.value;
          back_pos = back_pos + 1'b1;
          held = held + 1'b1;
        end
      end
      dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_PEEK_FRONT: begin
        if (held == '0) begin
          a.status = dq_pkg::STATUS_EMPTY;
        end else begin
          a.read_value = model_mem[front_pos];
          if (r.mode == dq_pkg::MODE_POP_FRONT) begin
            front_pos = front_pos + 1'b1;
            held = held - 1'b1;
          end
        end
      end
      dq_pkg::MODE_POP_BACK, dq_pkg::MODE_PEEK_BACK: begin
        if (held == '0) begin
          a.status = dq_pkg::STATUS_EMPTY;
        end else begin
          last = back_pos - 1'b1;
          a.read_value = model_mem[last];
          if (r.mode == dq_pkg::MODE_POP_BACK) begin
            back_pos = last;
            held = held - 1'b1;
          end
        end
      end
      dq_pkg::MODE_CLEAR: begin
        front_pos = '0;
        back_pos  = '0;
        held      = '0;
      end
      default: ;
    endcase
    a.occupancy = held;
    return a;
  endfunction

  function automatic logic [VW-1:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic add_marker(todo_kind_e k);
    todo_t t;
    t.kind  = k;
    t.phase = gen_phase;
    t.req   = '0;
    requests_todo.push_back(t);
  endtask

  task automatic add_req(dq_pkg::mode_t m, logic [VW-1:0] v);
    todo_t t;
    int    ph;
    ph = (gen_idx / PHASE_LEN) % 4;
    if (ph != gen_phase) begin
      add_marker(TODO_DRAIN);
      gen_phase = ph;
    end
    if (gen_idx == 40 || gen_idx == 640) add_marker(TODO_HOLD);
    t.kind       = TODO_REQ;
    t.phase      = ph;
    t.req.mode   = m;
    t.req.value  = v;
    requests_todo.push_back(t);
    gen_idx++;
    case (m)
      dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: if (gen_held < DEPTH_N) gen_held++;
      dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK:   if (gen_held > 0) gen_held--;
      dq_pkg::MODE_CLEAR:                              gen_held = 0;
      default: ;
    endcase
  endtask

  task automatic field_mismatch(string name, logic [VW-1:0] want, logic [VW-1:0] got);
    fails++;
    if (fails < 60)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
  endtask

  // driver
  always @(posedge clk) begin
    logic  offer;
    logic  idle;
    todo_t head;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        answers_due.push_back(deque_answer(in_data));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (requests_todo.size() > 0) begin
          head = requests_todo[0];
          case (head.kind)
            TODO_REQ: begin
              idle = (head.phase == 1 && $urandom_range(0, 99) < 86) ||
                     (head.phase == 3 && $urandom_range(0, 99) < 20);
              if (!idle) begin
                offer = 1'b1;
                in_data <= head.req;
                cur_phase <= head.phase;
                void'(requests_todo.pop_front());
              end
            end
            TODO_DRAIN: begin
              if (n_sent == n_recv) void'(requests_todo.pop_front());
            end
            default: begin
              hold_req <= hold_req + 1;
              void'(requests_todo.pop_front());
            end
          endcase
        end
        in_valid <= offer;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_ack  <= 0;
      hold_left <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    dq_pkg::rsp_t want;
    int           roll;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_recv <= n_recv + 1;
        if (answers_due.size() == 0) begin
          fails++;
          if (fails < 60)
            $display("%0t: unexpected response, expected none, actual %0h",
                     $realtime, out_data);
        end else begin
          want = answers_due.pop_front();
          if (out_data.status !== want.status)
            field_mismatch("status", VW'(want.status), VW'(out_data.status));
          if (out_data.read_value !== want.read_value)
            field_mismatch("read_value", want.read_value, out_data.read_value);
          if (out_data.occupancy !== want.occupancy)
            field_mismatch("occupancy", VW'(want.occupancy), VW'(out_data.occupancy));
        end
      end
      roll = $urandom_range(0, 99);
      if (hold_left != 0)      out_ready <= 1'b0;
      else if (cur_phase == 2) out_ready <= (roll >= 86);
      else if (cur_phase == 3) out_ready <= (roll >= 20);
      else                     out_ready <= 1'b1;
    end
  end

  initial begin
    int seg;
    int n;
    int r;
    dq_pkg::mode_t push_m;

    // directed: empty errors, both ends, extremes, unused mode, clear, wrap
    add_req(dq_pkg::MODE_POP_FRONT, '1);
    add_req(dq_pkg::MODE_POP_BACK, '0);
    add_req(dq_pkg::MODE_PEEK_FRONT, 32'h1234_5678);
    add_req(dq_pkg::MODE_PEEK_BACK, '1);
    add_req(dq_pkg::MODE_PUSH_BACK, '0);
    add_req(dq_pkg::MODE_PUSH_FRONT, '1);
    add_req(dq_pkg::MODE_PUSH_BACK, 32'hA5A5_A5A5);
    add_req(dq_pkg::MODE_PUSH_FRONT, 32'h5A5A_5A5A);
    add_req(dq_pkg::MODE_PEEK_FRONT, '0);
    add_req(dq_pkg::MODE_PEEK_BACK, '0);
    add_req(dq_pkg::MODE_POP_FRONT, '0);
    add_req(dq_pkg::MODE_POP_BACK, '0);
    add_req(dq_pkg::mode_t'(3'd7), '1);
    add_req(dq_pkg::MODE_CLEAR, '1);
    add_req(dq_pkg::MODE_PEEK_FRONT, '0);
    add_req(dq_pkg::MODE_PUSH_FRONT, 32'h0000_0001);
    add_req(dq_pkg::MODE_POP_BACK, '0);
    add_req(dq_pkg::MODE_PUSH_BACK, 32'h8000_0000);
    add_req(dq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF);
    add_req(dq_pkg::MODE_POP_FRONT, '0);
    add_req(dq_pkg::MODE_POP_FRONT, '0);
    add_req(dq_pkg::MODE_POP_BACK, '0);

    // random segments
    seg = 0;
    while (gen_idx < N_ITEMS) begin
      r = $urandom_range(0, 11);
      if (seg == 1 || seg == 12) r = 0;
      if (r == 0) begin
        while (gen_held < DEPTH_N) begin
          push_m = ($urandom_range(0, 1) == 0) ? dq_pkg::MODE_PUSH_FRONT
                                               : dq_pkg::MODE_PUSH_BACK;
          add_req(push_m, rand_word());
        end
        n = $urandom_range(1, 4);
        repeat (n) begin
          push_m = ($urandom_range(0, 1) == 0) ? dq_pkg::MODE_PUSH_FRONT
                                               : dq_pkg::MODE_PUSH_BACK;
          add_req(push_m, rand_word());
        end
        add_req(($urandom_range(0, 1) == 0) ? dq_pkg::MODE_PEEK_FRONT
                                            : dq_pkg::MODE_PEEK_BACK, rand_word());
      end else if (r == 1) begin
        while (gen_held > 0)
          add_req(($urandom_range(0, 1) == 0) ? dq_pkg::MODE_POP_FRONT
                                              : dq_pkg::MODE_POP_BACK, rand_word());
        n = $urandom_range(1, 3);
        repeat (n) add_req(dq_pkg::mode_t'($urandom_range(2, 5)), rand_word());
      end else if (r == 2) begin
        add_req(dq_pkg::MODE_CLEAR, rand_word());
      end else begin
        n = $urandom_range(20, 60);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 22)      add_req(dq_pkg::MODE_PUSH_FRONT, rand_word());
          else if (r < 44) add_req(dq_pkg::MODE_PUSH_BACK, rand_word());
          else if (r < 59) add_req(dq_pkg::MODE_POP_FRONT, rand_word());
          else if (r < 74) add_req(dq_pkg::MODE_POP_BACK, rand_word());
          else if (r < 83) add_req(dq_pkg::MODE_PEEK_FRONT, rand_word());
          else if (r < 92) add_req(dq_pkg::MODE_PEEK_BACK, rand_word());
          else if (r < 95) add_req(dq_pkg::MODE_CLEAR, rand_word());
          else             add_req(dq_pkg::mode_t'(3'd7), rand_word());
        end
      end
      seg++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (n_recv < gen_idx)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && answers_due.size() == 0 && n_recv == gen_idx) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
